// File: src/bsot_pkg.sv
`default_nettype none

package bsot_pkg;

	localparam int DIMS_DEFAULT = 3;
	localparam int NUM_STAGES = 6;
	localparam int MAG_W = 48;
	localparam int HALF_W = MAG_W / 2;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int RAD2_W = 62;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_CELL_X = 3'd3;
	localparam logic [2:0] REG_CELL_Y = 3'd4;
	localparam logic [2:0] REG_CELL_Z = 3'd5;
	localparam logic [2:0] REG_INNER = 3'd6;
	localparam logic [2:0] REG_OUTER = 3'd7;

	localparam logic signed [31:0] ORIGIN_RESET = 32'sd0;
	localparam logic [30:0] CELL_RESET = 31'd65536;
	localparam logic signed [31:0] RADIUS_RESET = -32'sd65536;

	typedef logic [NUM_STAGES-1:0] adv_t;
	typedef logic [SQ_W-1:0] sq_t;
	typedef logic [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic use_in;
		logic use_out;
		logic [RAD2_W-1:0] rin2;
		logic [RAD2_W-1:0] rout2;
	} bounds_t;

endpackage

`default_nettype wire

// File: src/bsot_axis.sv
`default_nettype none

module bsot_axis (
	input  logic                  clk,
	input  bsot_pkg::adv_t        adv,
	input  logic signed [31:0]    origin,
	input  logic [30:0]           cell_size,
	input  logic signed [15:0]    lower,
	input  logic signed [15:0]    upper,
	output bsot_pkg::sq_t         sq_s4 [2]
);
	import bsot_pkg::*;

	logic signed [16:0] idx [2];
	logic signed [48:0] full_prod [2];
	logic signed [48:0] coord [2];
	logic signed [47:0] prod_s1 [2];
	logic [MAG_W-1:0] mag_s2 [2];
	logic [MAG_W-1:0] aa_s3 [2];
	logic [MAG_W-1:0] ab_s3 [2];
	logic [MAG_W-1:0] bb_s3 [2];

	// Side 0 is the lower face, side 1 the far face of the upper cell.
	always_comb begin
		idx[0] = 17'(lower);
		idx[1] = 17'(upper) + 17'sd1;
		for (int i = 0; i < 2; i++) begin
			full_prod[i] = $signed({1'b0, cell_size}) * idx[i];
			coord[i] = 49'(origin) + 49'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (adv[0]) begin
				prod_s1[i] <= full_prod[i][47:0];
			end
			if (adv[1]) begin
				mag_s2[i] <= coord[i][48] ? MAG_W'(-coord[i]) : coord[i][MAG_W-1:0];
			end
			if (adv[2]) begin
				aa_s3[i] <= mag_s2[i][MAG_W-1:HALF_W] * mag_s2[i][MAG_W-1:HALF_W];
				ab_s3[i] <= mag_s2[i][MAG_W-1:HALF_W] * mag_s2[i][HALF_W-1:0];
				bb_s3[i] <= mag_s2[i][HALF_W-1:0] * mag_s2[i][HALF_W-1:0];
			end
			if (adv[3]) begin
				sq_s4[i] <= {aa_s3[i], {MAG_W{1'b0}}}
					+ {{(HALF_W - 1){1'b0}}, ab_s3[i], {(HALF_W + 1){1'b0}}}
					+ {{MAG_W{1'b0}}, bb_s3[i]};
			end
		end
	end

endmodule

`default_nettype wire

// File: src/bsot_score.sv
`default_nettype none

module bsot_score #(
	parameter int DIMS = bsot_pkg::DIMS_DEFAULT
) (
	input  logic                  clk,
	input  bsot_pkg::adv_t        adv,
	input  bsot_pkg::sq_t         sq_s4 [DIMS][2],
	input  bsot_pkg::bounds_t     bounds,
	output logic                  overlap_s6
);
	import bsot_pkg::*;

	localparam int NCORNERS = 1 << DIMS;

	sum_t sum_c [NCORNERS];
	sum_t sum_s5 [NCORNERS];
	logic [NCORNERS-1:0] beyond_out;
	logic [NCORNERS-1:0] beyond_in;

	for (genvar c = 0; c < NCORNERS; c++) begin : g_corner
		always_comb begin
			sum_c[c] = '0;
			for (int d = 0; d < DIMS; d++) begin
				sum_c[c] = sum_c[c] + SUM_W'(sq_s4[d][1'((c >> d) & 1)]);
			end
		end

		always_comb begin
			logic in_c;
			logic out_c;
			in_c = bounds.use_in && (sum_s5[c] < SUM_W'(bounds.rin2));
			out_c = bounds.use_out && (sum_s5[c] > SUM_W'(bounds.rout2));
			beyond_out[c] = out_c && !in_c;
			beyond_in[c] = in_c && !out_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			sum_s5 <= sum_c;
		end
		if (adv[5]) begin
			overlap_s6 <= !((&beyond_out) || (&beyond_in));
		end
	end

endmodule

`default_nettype wire

// File: src/box_shell_overlap_test.sv
// Each accepted input beat moves through the pipeline stages in order and becomes one result beat.
// Throughput: one box per cycle while out_stall is low; every stage holds one box and a stage
// takes a new one whenever it is empty or its contents move on.
// Reset clears all pipeline valid bits and returns the configuration
// registers to their reset values; results in flight are discarded.
`default_nettype none

module box_shell_overlap_test #(
	parameter int DIMS = bsot_pkg::DIMS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] lower_x,
	input  logic signed [15:0] lower_y,
	input  logic signed [15:0] lower_z,
	input  logic signed [15:0] upper_x,
	input  logic signed [15:0] upper_y,
	input  logic signed [15:0] upper_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               overlaps_shell
);
	import bsot_pkg::*;

	logic signed [31:0] origin_q [3];
	logic [30:0] cell_q [3];
	logic signed [31:0] inner_q;
	logic signed [31:0] outer_q;
	logic [RAD2_W-1:0] rin2_q;
	logic [RAD2_W-1:0] rout2_q;
	bounds_t bounds;

	logic [NUM_STAGES-1:0] vld_s;
	logic [NUM_STAGES-1:0] vld_prev;
	adv_t adv;

	logic signed [15:0] lower_idx [3];
	logic signed [15:0] upper_idx [3];
	sq_t sq_s4 [DIMS][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < 3; d++) begin
				origin_q[d] <= ORIGIN_RESET;
				cell_q[d] <= CELL_RESET;
			end
			inner_q <= RADIUS_RESET;
			outer_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: origin_q[0] <= cfg_data;
				REG_ORIGIN_Y: origin_q[1] <= cfg_data;
				REG_ORIGIN_Z: origin_q[2] <= cfg_data;
				REG_CELL_X:   cell_q[0] <= cfg_data[30:0];
				REG_CELL_Y:   cell_q[1] <= cfg_data[30:0];
				REG_CELL_Z:   cell_q[2] <= cfg_data[30:0];
				REG_INNER:    inner_q <= cfg_data;
				REG_OUTER:    outer_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rin2_q <= inner_q[30:0] * inner_q[30:0];
		rout2_q <= outer_q[30:0] * outer_q[30:0];
	end

	assign bounds.use_in = !inner_q[31];
	assign bounds.use_out = !outer_q[31];
	assign bounds.rin2 = rin2_q;
	assign bounds.rout2 = rout2_q;

	// A stage loads if empty or if the next one loads; the last one if out_stall is low.
	always_comb begin
		adv[NUM_STAGES-1] = !vld_s[NUM_STAGES-1] || !out_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
		vld_prev = {vld_s[NUM_STAGES-2:0], in_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_prev[k];
				end
			end
		end
	end

	assign in_stall = !adv[0];
	assign out_valid = vld_s[NUM_STAGES-1];

	assign lower_idx = '{lower_x, lower_y, lower_z};
	assign upper_idx = '{upper_x, upper_y, upper_z};

	for (genvar d = 0; d < DIMS; d++) begin : g_axis
		bsot_axis u_axis (
			.clk       (clk),
			.adv       (adv),
			.origin    (origin_q[d]),
			.cell_size (cell_q[d]),
			.lower     (lower_idx[d]),
			.upper     (upper_idx[d]),
			.sq_s4     (sq_s4[d])
		);
	end

	bsot_score #(
		.DIMS (DIMS)
	) u_score (
		.clk        (clk),
		.adv        (adv),
		.sq_s4      (sq_s4),
		.bounds     (bounds),
		.overlap_s6 (overlaps_shell)
	);

endmodule

`default_nettype wire
